// ===== sv/pth_pkg.sv =====
package pth_pkg;

	localparam int RegIdxW = 3;
	localparam int CfgDataW = 64;

	typedef enum logic [RegIdxW-1:0] {
		REG_CAL_TEMP      = 3'd0,
		REG_CAL_PRESS_A   = 3'd1,
		REG_CAL_PRESS_B   = 3'd2,
		REG_CAL_PRESS_HUM = 3'd3,
		REG_CAL_HUM       = 3'd4
	} reg_idx_t;

	localparam int DivBits = 64;

	// Signed 16-bit operand slice, sign extended to 64 bits
	function automatic logic signed [63:0] sx16(input logic [15:0] v);
		sx16 = 64'(signed'(v));
	endfunction

endpackage

// ===== sv/pth_div.sv =====
// Pipelined 64-bit signed divider, one quotient bit per stage, truncating toward zero.
module pth_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        vld,
	input  logic [63:0] num,
	input  logic [63:0] den,
	input  logic [63:0] side,
	output logic        out_vld,
	output logic [63:0] quo,
	output logic [63:0] out_side
);
	import pth_pkg::*;

	logic               vld_q  [DivBits+1];
	logic [63:0]        rem_q  [DivBits+1];
	logic [63:0]        quo_q  [DivBits+1];
	logic [63:0]        den_q  [DivBits+1];
	logic               neg_q  [DivBits+1];
	logic [63:0]        side_q [DivBits+1];

	// Load magnitudes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else begin
			vld_q[0] <= vld;
		end
	end

	always_ff @(posedge clk) begin
		rem_q[0]  <= '0;
		quo_q[0]  <= num[63] ? 64'(0 - num) : num;
		den_q[0]  <= den[63] ? 64'(0 - den) : den;
		neg_q[0]  <= num[63] ^ den[63];
		side_q[0] <= side;
	end

	// One restoring step per stage
	for (genvar k = 0; k < DivBits; k++) begin : g_step
		logic [64:0] trial;
		logic [64:0] diff;
		always_comb begin
			trial = {rem_q[k], quo_q[k][63]};
			diff  = trial - {1'b0, den_q[k]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else begin
				vld_q[k+1] <= vld_q[k];
			end
		end
		always_ff @(posedge clk) begin
			rem_q[k+1]  <= diff[64] ? trial[63:0] : diff[63:0];
			quo_q[k+1]  <= {quo_q[k][62:0], ~diff[64]};
			den_q[k+1]  <= den_q[k];
			neg_q[k+1]  <= neg_q[k];
			side_q[k+1] <= side_q[k];
		end
	end

	assign out_vld  = vld_q[DivBits];
	assign quo      = neg_q[DivBits] ? 64'(0 - quo_q[DivBits]) : quo_q[DivBits];
	assign out_side = side_q[DivBits];

endmodule

// ===== sv/pth_sensor_compensation_core.sv =====
// Compensation core: accepts one raw sample set (temperature, pressure, humidity) in every
// clock cycle while busy is low (busy is never raised) and emits one result item per sample
// on done. The pipeline depth is set by the pressure divide: five input stages, a pipelined
// restoring divider of 65 register stages that retires one quotient bit per stage, and the
// post-divide stages A to D; the other formulas run in short multiply stages and wait
// alongside it. Results cannot be held off. The calibration registers must not be written
// while samples are in flight.
module pth_sensor_compensation_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [19:0] raw_temperature,
	input  logic [19:0] raw_pressure,
	input  logic [15:0] raw_humidity,
	input  logic        cfg_we,
	input  logic [pth_pkg::RegIdxW-1:0]  cfg_idx,
	input  logic [pth_pkg::CfgDataW-1:0] cfg_data,
	output logic        done,
	output logic signed [23:0] temperature_centi,
	output logic signed [31:0] fine_temperature,
	output logic [31:0] pressure_q24_8,
	output logic        pressure_valid,
	output logic [16:0] humidity_q22_10
);
	import pth_pkg::*;

	localparam int DlyN = DivBits + 1;

	logic [47:0] ct_q;
	logic [63:0] cpa_q, cpb_q;
	logic [47:0] cph_q;
	logic [39:0] ch_q;

	// Write calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ct_q <= '0; cpa_q <= '0; cpb_q <= '0; cph_q <= '0; ch_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_CAL_TEMP:      ct_q  <= cfg_data[47:0];
				REG_CAL_PRESS_A:   cpa_q <= cfg_data;
				REG_CAL_PRESS_B:   cpb_q <= cfg_data;
				REG_CAL_PRESS_HUM: cph_q <= cfg_data[47:0];
				REG_CAL_HUM:       ch_q  <= cfg_data[39:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic signed [63:0] h1, h2, h3, h4, h5, h6;
	always_comb begin
		t1 = 64'(ct_q[15:0]);    t2 = sx16(ct_q[31:16]);  t3 = sx16(ct_q[47:32]);
		p1 = 64'(cpa_q[15:0]);   p2 = sx16(cpa_q[31:16]); p3 = sx16(cpa_q[47:32]);
		p4 = sx16(cpa_q[63:48]); p5 = sx16(cpb_q[15:0]);  p6 = sx16(cpb_q[31:16]);
		p7 = sx16(cpb_q[47:32]); p8 = sx16(cpb_q[63:48]); p9 = sx16(cph_q[15:0]);
		h1 = 64'(cph_q[23:16]);  h2 = sx16(cph_q[39:24]); h3 = 64'(cph_q[47:40]);
		h4 = sx16(ch_q[15:0]);   h5 = sx16(ch_q[31:16]);  h6 = 64'(signed'(ch_q[39:32]));
	end

	// ---------------- stage 1: temperature products
	logic v_s1;
	logic signed [63:0] ta_s1, tb_s1;
	logic [19:0] adp_s1;
	logic [15:0] adh_s1;
	logic signed [63:0] da, db;
	always_comb begin
		da = 64'(raw_temperature >> 3) - (t1 <<< 1);
		db = 64'(raw_temperature >> 4) - t1;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		ta_s1  <= (da * t2) >>> 11;
		tb_s1  <= (db * db) >>> 12;
		adp_s1 <= raw_pressure;
		adh_s1 <= raw_humidity;
	end

	// ---------------- stage 2: fine temperature
	logic v_s2;
	logic signed [31:0] tf_s2;
	logic [19:0] adp_s2;
	logic [15:0] adh_s2;
	logic signed [63:0] tsum;
	always_comb tsum = ta_s1 + ((tb_s1 * t3) >>> 14);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		tf_s2 <= tsum[31:0]; adp_s2 <= adp_s1; adh_s2 <= adh_s1;
	end

	// ---------------- stage 3: first pressure and humidity products
	logic v_s3;
	logic signed [31:0] tf_s3;
	logic signed [63:0] v1sq_s3, v1p5_s3, v1p2_s3;
	logic signed [31:0] hx_s3, hy_s3, hz_s3;
	logic [19:0] adp_s3;
	logic signed [63:0] pv1;
	logic signed [31:0] hv1;
	always_comb begin
		pv1 = 64'(tf_s2) - 64'sd128000;
		hv1 = tf_s2 - 32'sd76800;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		tf_s3   <= tf_s2;
		v1sq_s3 <= pv1 * pv1;
		v1p5_s3 <= pv1 * p5;
		v1p2_s3 <= pv1 * p2;
		hx_s3   <= ((signed'(32'(adh_s2)) <<< 14) - (32'(h4) <<< 20) - 32'(h5) * hv1
			+ 32'sd16384) >>> 15;
		hy_s3   <= (hv1 * 32'(h6)) >>> 10;
		hz_s3   <= ((hv1 * 32'(h3)) >>> 11) + 32'sd32768;
		adp_s3  <= adp_s2;
	end

	// ---------------- stage 4: pressure terms
	logic v_s4;
	logic signed [31:0] tf_s4;
	logic signed [63:0] v2_s4, pv1_s4;
	logic signed [31:0] hx_s4, hy_s4;
	logic [19:0] adp_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		tf_s4  <= tf_s3;
		v2_s4  <= v1sq_s3 * p6 + (v1p5_s3 <<< 17) + (p4 <<< 35);
		pv1_s4 <= ((v1sq_s3 * p3) >>> 8) + (v1p2_s3 <<< 12);
		hx_s4  <= hx_s3;
		hy_s4  <= (hy_s3 * hz_s3) >>> 10;
		adp_s4 <= adp_s3;
	end

	// ---------------- stage 5: divisor and numerator
	logic v_s5;
	logic signed [31:0] tf_s5;
	logic signed [63:0] den_s5, num_s5;
	logic signed [31:0] hx_s5, hy_s5;
	logic signed [63:0] pn;
	always_comb pn = ((64'sd1048576 - 64'(adp_s4)) <<< 31) - v2_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		tf_s5  <= tf_s4;
		den_s5 <= ((64'sh8000_0000_0000 + pv1_s4) * p1) >>> 33;
		num_s5 <= pn * 64'sd3125;
		hx_s5  <= hx_s4;
		hy_s5  <= ((hy_s4 + 32'sd2097152) * 32'(h2) + 32'sd8192) >>> 14;
	end

	// ---------------- stage 6: humidity finish, enter divider
	logic signed [31:0] hr_s6;
	logic signed [31:0] hr;
	always_comb hr = hx_s5 * hy_s5;
	always_ff @(posedge clk) hr_s6 <= hr;

	logic signed [31:0] hs_s7, hr_s7;
	logic signed [31:0] hs1;
	always_comb begin
		hs1 = hr_s6 >>> 15;
		hs1 = (hs1 * hs1) >>> 7;
	end
	always_ff @(posedge clk) begin
		hs_s7 <= hs1; hr_s7 <= hr_s6;
	end
	logic [16:0] hum_s8;
	logic signed [31:0] hfin;
	always_comb begin
		hfin = hr_s7 - ((hs_s7 * 32'(h1)) >>> 4);
		if (hfin < 0) hfin = 0;
		else if (hfin > 32'sd419430400) hfin = 32'sd419430400;
	end
	always_ff @(posedge clk) hum_s8 <= 17'(hfin >>> 12);

	// Align humidity with the divider and the three post-divide stages
	logic [16:0] hum_d_q [DlyN];
	always_ff @(posedge clk) begin
		hum_d_q[0] <= hum_s8;
		for (int i = 1; i < DlyN; i++) hum_d_q[i] <= hum_d_q[i-1];
	end

	logic dzero;
	logic [63:0] side;
	assign dzero = (den_s5 == 64'sd0);
	assign side  = {31'b0, dzero, tf_s5};

	logic        dv_vld;
	logic [63:0] dv_quo, dv_side;
	pth_div u_div (
		.clk(clk), .arst_n(arst_n), .vld(v_s5), .num(num_s5),
		.den(dzero ? 64'd1 : den_s5), .side(side),
		.out_vld(dv_vld), .quo(dv_quo), .out_side(dv_side)
	);

	// ---------------- post-divide stage A
	logic va_q;
	logic signed [63:0] pa_s9, pq_s9;
	logic signed [31:0] tf_s9;
	logic dz_s9;
	logic signed [63:0] qa;
	always_comb qa = signed'(dv_quo) >>> 13;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) va_q <= 1'b0;
		else va_q <= dv_vld;
	end
	always_ff @(posedge clk) begin
		pq_s9 <= dv_quo;
		pa_s9 <= p9 * qa;
		tf_s9 <= dv_side[31:0];
		dz_s9 <= dv_side[32];
	end

	// Stage B: split the wide product into 32-bit partial products
	logic vb_q;
	logic [63:0] ll_s10;
	logic [31:0] cr_s10;
	logic signed [63:0] pb_s10, pq_s10;
	logic signed [31:0] tf_s10;
	logic dz_s10;
	logic signed [63:0] qb;
	always_comb qb = pq_s9 >>> 13;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vb_q <= 1'b0;
		else vb_q <= va_q;
	end
	always_ff @(posedge clk) begin
		ll_s10 <= 64'(pa_s9[31:0]) * 64'(qb[31:0]);
		cr_s10 <= pa_s9[63:32] * qb[31:0] + pa_s9[31:0] * qb[63:32];
		pb_s10 <= (p8 * pq_s9) >>> 19;
		pq_s10 <= pq_s9; tf_s10 <= tf_s9; dz_s10 <= dz_s9;
	end

	// Stage C: combine partial products, add correction terms
	logic vc_q;
	logic signed [63:0] pt_s11, pq_s11;
	logic signed [31:0] tf_s11;
	logic dz_s11;
	logic [63:0] pm;
	always_comb pm = ll_s10 + {cr_s10, 32'b0};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vc_q <= 1'b0;
		else vc_q <= vb_q;
	end
	always_ff @(posedge clk) begin
		pt_s11 <= (signed'(pm) >>> 25) + pb_s10;
		pq_s11 <= pq_s10; tf_s11 <= tf_s10; dz_s11 <= dz_s10;
	end

	// Stage D: saturate and register outputs
	logic signed [63:0] pf, tcf;
	logic [31:0] psat;
	logic signed [23:0] tsat;
	always_comb begin
		pf = ((pq_s11 + pt_s11) >>> 8) + (p7 <<< 4);
		if (pf < 0) psat = '0;
		else if (pf > 64'sh0_FFFF_FFFF) psat = '1;
		else psat = pf[31:0];
		tcf = (64'(tf_s11) * 64'sd5 + 64'sd128) >>> 8;
		if (tcf < -64'sd8388608) tsat = 24'sh800000;
		else if (tcf > 64'sd8388607) tsat = 24'sh7FFFFF;
		else tsat = tcf[23:0];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vc_q;
	end
	always_ff @(posedge clk) begin
		temperature_centi <= tsat;
		fine_temperature  <= tf_s11;
		pressure_q24_8    <= dz_s11 ? 32'd0 : psat;
		pressure_valid    <= ~dz_s11;
		humidity_q22_10   <= hum_d_q[DlyN-1];
	end

endmodule

// ===== sv/pth_sva.sv =====
module pth_sva (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] pressure_q24_8,
	input logic        pressure_valid,
	input logic [16:0] humidity_q22_10
);
	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_inval_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !pressure_valid |-> pressure_q24_8 == 32'd0)
		else $error("invalid pressure not zero");
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> humidity_q22_10 <= 17'd102400)
		else $error("humidity out of range");
	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(start, 74) && $past(arst_n, 74) |-> !done)
		else $error("result without item");
endmodule

bind pth_sensor_compensation_core pth_sva u_sva (.*);
